### rtl/hbm_pkg.sv
// shared constants, codes and types of the heartbeat monitor
package hbm_pkg;

  // device count and time width
  localparam int unsigned DEVICES   = 8;
  localparam int unsigned TIME_BITS = 32;
  localparam int unsigned SUM_W     = TIME_BITS + 1;
  localparam int unsigned DEV_W     = (DEVICES > 1) ? $clog2(DEVICES) : 1;

  // field widths fixed by the interface
  localparam int unsigned OP_W    = 2;
  localparam int unsigned DEVF_W  = 3;
  localparam int unsigned EVT_W   = 32;
  localparam int unsigned VEC_W   = 16;
  localparam int unsigned MASK_W  = 8;
  localparam int unsigned TO_W    = 8;
  localparam int unsigned CFG_W   = 64;
  localparam int unsigned CIDX_W  = 3;

  // item opcodes
  typedef enum logic [OP_W-1:0] {
    OP_START     = 2'd0,
    OP_HEARTBEAT = 2'd1,
    OP_TICK      = 2'd2,
    OP_QUERY     = 2'd3
  } op_e;

  // per-device health codes
  typedef enum logic [1:0] {
    ST_NOT_CONFIGURED  = 2'd0,
    ST_NOT_INITIALISED = 2'd1,
    ST_NOT_OK          = 2'd2,
    ST_OK              = 2'd3
  } health_e;

  // configuration register indexes
  localparam logic [CIDX_W-1:0] CFG_APPLICABLE = 3'd0;
  localparam logic [CIDX_W-1:0] CFG_CONFIGURED = 3'd1;
  localparam logic [CIDX_W-1:0] CFG_CAMERA     = 3'd2;
  localparam logic [CIDX_W-1:0] CFG_INIT_TO    = 3'd3;
  localparam logic [CIDX_W-1:0] CFG_ERROR_TO   = 3'd4;

  // configuration reset values
  localparam logic [MASK_W-1:0] APPLICABLE_RST = 8'hFF;
  localparam logic [MASK_W-1:0] CONFIGURED_RST = 8'hFF;
  localparam logic [MASK_W-1:0] CAMERA_RST     = 8'hC0;
  localparam logic [CFG_W-1:0]  INIT_TO_RST    = 64'h140F0A0A0A0A0A0A;
  localparam logic [CFG_W-1:0]  ERROR_TO_RST   = 64'h1E19141414141414;

endpackage

### rtl/hbm_in_if.sv
// input item channel of the heartbeat monitor
interface hbm_in_if;
  logic                           valid;
  logic                           ready;
  logic [hbm_pkg::OP_W-1:0]       opcode;
  logic [hbm_pkg::DEVF_W-1:0]     device;
  logic [hbm_pkg::EVT_W-1:0]      event_time;
  logic                           cameras_required;

  modport source (output valid, output opcode, output device, output event_time,
                  output cameras_required, input ready);
  modport sink   (input valid, input opcode, input device, input event_time,
                  input cameras_required, output ready);
endinterface

### rtl/hbm_out_if.sv
// result item channel of the heartbeat monitor
interface hbm_out_if;
  logic                       valid;
  logic                       ready;
  logic [hbm_pkg::VEC_W-1:0]  state_vector;
  logic [1:0]                 queried_state;

  modport source (output valid, output state_vector, output queried_state, input ready);
  modport sink   (input valid, input state_vector, input queried_state, output ready);
endinterface

### rtl/multi_device_heartbeat_monitor.sv
// heartbeat monitor top level: sequencer around one shared adder and comparator
// a tick walks the devices one by one through the shared adder-comparator, adding a silence check when judged
// one item at a time; the next transfer is taken once the result is in the output register
// reset clears all device states, last-good times, start time and config to defaults
module multi_device_heartbeat_monitor (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  hbm_in_if.sink                        in_i,
  hbm_out_if.source                     out_o,
  input  logic                          cfg_we_i,
  input  logic [hbm_pkg::CIDX_W-1:0]    cfg_idx_i,
  input  logic [hbm_pkg::CFG_W-1:0]     cfg_data_i
);
  import hbm_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_HB,
    S_EVAL,
    S_ERR,
    S_DONE
  } fsm_e;

  // configuration registers
  logic [MASK_W-1:0] applicable_q, configured_q, camera_q;
  logic [CFG_W-1:0]  init_to_q, error_to_q;

  // sequencer and item registers
  fsm_e                 state_q;
  logic [DEV_W-1:0]     cnt_q;
  op_e                  op_q;
  logic [DEVF_W-1:0]    dev_q;
  logic [TIME_BITS-1:0] t_q;
  logic                 cams_q;

  // monitor state
  health_e              health_q [DEVICES];
  logic [TIME_BITS-1:0] lgt_q [DEVICES];
  logic [TIME_BITS-1:0] start_q;

  // output register
  logic                 out_valid_q;
  logic [VEC_W-1:0]     out_vec_q;
  logic [1:0]           out_qs_q;

  // shared unit operands and result
  logic [DEV_W-1:0]     rd_idx;
  logic [TIME_BITS-1:0] unit_a;
  logic [TO_W-1:0]      unit_b;
  logic [SUM_W-1:0]     unit_sum;
  logic                 unit_gt;
  logic                 dev_ok;
  logic                 last_dev;
  logic                 in_xfer;
  logic [VEC_W-1:0]     vec;
  logic [1:0]           qs;

  assign in_xfer  = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == S_IDLE);
  assign dev_ok   = ({1'b0, dev_q} < (DEVF_W + 1)'(DEVICES));
  assign last_dev = (cnt_q == DEV_W'(DEVICES - 1));
  assign rd_idx   = (state_q == S_HB) ? dev_q[DEV_W-1:0] : cnt_q;

  // operand select for the shared adder-comparator
  always_comb begin
    unit_a = '0;
    unit_b = '0;
    case (state_q)
      S_HB: begin
        unit_a = lgt_q[rd_idx];
      end
      S_EVAL: begin
        unit_a = start_q;
        unit_b = init_to_q[cnt_q*TO_W +: TO_W];
      end
      S_ERR: begin
        unit_a = lgt_q[rd_idx];
        unit_b = error_to_q[cnt_q*TO_W +: TO_W];
      end
      default: begin
        unit_a = '0;
        unit_b = '0;
      end
    endcase
  end

  // 33-bit sum never wraps
  assign unit_sum = {1'b0, unit_a} + SUM_W'(unit_b);
  assign unit_gt  = ({1'b0, t_q} > unit_sum);

  // packed state vector and queried state
  always_comb begin
    vec = '0;
    for (int i = 0; i < DEVICES; i++) begin
      vec[2*i +: 2] = health_q[i];
    end
    qs = ST_NOT_CONFIGURED;
    if (op_q == OP_QUERY && dev_ok) begin
      qs = health_q[dev_q[DEV_W-1:0]];
    end
  end

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      applicable_q <= APPLICABLE_RST;
      configured_q <= CONFIGURED_RST;
      camera_q     <= CAMERA_RST;
      init_to_q    <= INIT_TO_RST;
      error_to_q   <= ERROR_TO_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_APPLICABLE: applicable_q <= cfg_data_i[MASK_W-1:0];
        CFG_CONFIGURED: configured_q <= cfg_data_i[MASK_W-1:0];
        CFG_CAMERA:     camera_q     <= cfg_data_i[MASK_W-1:0];
        CFG_INIT_TO:    init_to_q    <= cfg_data_i;
        CFG_ERROR_TO:   error_to_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // sequencer, monitor state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      op_q        <= OP_START;
      dev_q       <= '0;
      t_q         <= '0;
      cams_q      <= 1'b0;
      start_q     <= '0;
      out_valid_q <= 1'b0;
      out_vec_q   <= '0;
      out_qs_q    <= '0;
      for (int i = 0; i < DEVICES; i++) begin
        health_q[i] <= ST_NOT_CONFIGURED;
        lgt_q[i]    <= '0;
      end
    end else begin
      // result transfer frees the output register; the done step reloads it itself
      if (out_valid_q && out_o.ready && state_q != S_DONE) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_xfer) begin
            op_q   <= op_e'(in_i.opcode);
            dev_q  <= in_i.device;
            t_q    <= TIME_BITS'(in_i.event_time);
            cams_q <= in_i.cameras_required;
            cnt_q  <= '0;
            case (op_e'(in_i.opcode))
              OP_START: begin
                start_q <= TIME_BITS'(in_i.event_time);
                state_q <= S_DONE;
              end
              OP_HEARTBEAT: state_q <= S_HB;
              OP_TICK:      state_q <= S_EVAL;
              default:      state_q <= S_DONE;
            endcase
          end
        end
        // raise last-good time if the message is later
        S_HB: begin
          if (dev_ok && unit_gt) begin
            lgt_q[rd_idx] <= t_q;
          end
          state_q <= S_DONE;
        end
        // settle check for one device
        S_EVAL: begin
          if (!applicable_q[cnt_q]) begin
            cnt_q   <= cnt_q + 1'b1;
            state_q <= last_dev ? S_DONE : S_EVAL;
          end else if (health_q[cnt_q] == ST_NOT_CONFIGURED) begin
            if (configured_q[cnt_q]) begin
              health_q[cnt_q] <= ST_NOT_INITIALISED;
            end
            cnt_q   <= cnt_q + 1'b1;
            state_q <= last_dev ? S_DONE : S_EVAL;
          end else if (unit_gt) begin
            // camera counts as fresh while not required
            if (camera_q[cnt_q] && !cams_q) begin
              lgt_q[cnt_q] <= t_q;
            end
            state_q <= S_ERR;
          end else begin
            cnt_q   <= cnt_q + 1'b1;
            state_q <= last_dev ? S_DONE : S_EVAL;
          end
        end
        // silence check for one device
        S_ERR: begin
          health_q[cnt_q] <= unit_gt ? ST_NOT_OK : ST_OK;
          cnt_q   <= cnt_q + 1'b1;
          state_q <= last_dev ? S_DONE : S_EVAL;
        end
        // load result once the output register is free
        S_DONE: begin
          if (!out_valid_q || out_o.ready) begin
            out_valid_q <= 1'b1;
            out_vec_q   <= vec;
            out_qs_q    <= qs;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.state_vector  = out_vec_q;
  assign out_o.queried_state = out_qs_q;

`ifndef SYNTHESIS
  // an accepted item always makes the block busy
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> state_q != S_IDLE)
    else $error("block idle right after an input transfer");

  // device counter stays in range while walking devices
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EVAL || state_q == S_ERR) |-> cnt_q <= DEV_W'(DEVICES - 1))
    else $error("device counter out of range");

  // a new result is only loaded from the done step
  a_load_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_q ##1 out_valid_q) |-> $past(state_q == S_DONE))
    else $error("result loaded outside the done step");

  // device 0, once configured, never drops back to not configured
  a_no_fallback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    health_q[0] != ST_NOT_CONFIGURED |=> health_q[0] != ST_NOT_CONFIGURED)
    else $error("device state fell back to not configured");
`endif

endmodule

### sim/testbench.sv
// self-checking testbench of the heartbeat monitor: directed and random stimulus, own model, transfer checks
module testbench;
  import hbm_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 600000;
  localparam int unsigned PHASE_ITEMS  = 200;
  localparam int unsigned PHASES       = 10;
  localparam int unsigned LONG_HOLD    = 300;
  localparam int unsigned TAIL_CYCLES  = 20;

  // one input item and one result item
  typedef struct packed {
    op_e                op;
    logic [DEVF_W-1:0]  dev;
    logic [EVT_W-1:0]   t;
    logic               cams;
  } hb_item_t;

  typedef struct packed {
    logic [VEC_W-1:0] vec;
    health_e          q;
  } hb_status_t;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                cfg_we;
  logic [CIDX_W-1:0]   cfg_idx;
  logic [CFG_W-1:0]    cfg_data;

  hbm_in_if  in_ch ();
  hbm_out_if out_ch ();

  multi_device_heartbeat_monitor dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_i       (in_ch),
    .out_o      (out_ch),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  // pending items and predicted results
  hb_item_t   item_q [$];
  hb_status_t status_q [$];

  // model of the monitor: configuration and device state
  logic [MASK_W-1:0] appl_m;
  logic [MASK_W-1:0] conf_m;
  logic [MASK_W-1:0] cam_m;
  logic [CFG_W-1:0]  init_to;
  logic [CFG_W-1:0]  err_to;
  health_e           health [DEVICES] = '{default: ST_NOT_CONFIGURED};
  logic [EVT_W-1:0]  last_good [DEVICES] = '{default: '0};
  logic [EVT_W-1:0]  start_t = '0;

  // traffic shaping
  int          src_pct;
  int          snk_pct;
  int          src_gap = 0;
  int          snk_gap = 0;
  int          hold_left = 0;
  int          hold_reqs;
  int          hold_seen = 0;
  int          mismatches = 0;
  int          step_max;
  logic [31:0] wall;
  int unsigned cycle_cnt;

  always #5 clk = ~clk;

  task automatic report_mismatch(input string what);
    $display("%0t: mismatch: %s", $time, what);
    mismatches++;
  endtask

  // apply one item to the model and return the result it must produce
  function automatic hb_status_t advance_health(input hb_item_t it);
    hb_status_t       st;
    logic [SUM_W-1:0] limit;
    st.vec = '0;
    st.q   = ST_NOT_CONFIGURED;
    case (it.op)
      OP_START: begin
        start_t = it.t;
      end
      OP_HEARTBEAT: begin
        if (it.t > last_good[it.dev]) last_good[it.dev] = it.t;
      end
      OP_TICK: begin
        for (int i = 0; i < DEVICES; i++) begin
          // 33-bit sums never wrap
          limit = SUM_W'(start_t) + SUM_W'(init_to[8*i +: 8]);
          if (!appl_m[i]) begin
          end else if (health[i] == ST_NOT_CONFIGURED) begin
            if (conf_m[i]) health[i] = ST_NOT_INITIALISED;
          end else if (SUM_W'(it.t) > limit) begin
            if (cam_m[i] && !it.cams) last_good[i] = it.t;
            limit = SUM_W'(last_good[i]) + SUM_W'(err_to[8*i +: 8]);
            health[i] = (SUM_W'(it.t) > limit) ? ST_NOT_OK : ST_OK;
          end
        end
      end
      default: begin
        st.q = health[it.dev];
      end
    endcase
    for (int i = 0; i < DEVICES; i++) st.vec[2*i +: 2] = health[i];
    return st;
  endfunction

  // driver: offers items from the queue, predicts on each transfer
  always @(posedge clk) begin : drive
    hb_item_t seen;
    hb_item_t nxt;
    if (!rst_n) begin
      in_ch.valid            <= 1'b0;
      in_ch.opcode           <= OP_START;
      in_ch.device           <= '0;
      in_ch.event_time       <= '0;
      in_ch.cameras_required <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        seen.op   = op_e'(in_ch.opcode);
        seen.dev  = in_ch.device;
        seen.t    = in_ch.event_time;
        seen.cams = in_ch.cameras_required;
        status_q.push_back(advance_health(seen));
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (src_gap > 0) begin
          src_gap--;
          in_ch.valid <= 1'b0;
        end else if (item_q.size() == 0) begin
          in_ch.valid <= 1'b0;
        end else if (src_pct != 0 && $urandom_range(1, 100) <= src_pct) begin
          src_gap = $urandom_range(0, 18);
          in_ch.valid <= 1'b0;
        end else begin
          nxt = item_q.pop_front();
          in_ch.valid            <= 1'b1;
          in_ch.opcode           <= nxt.op;
          in_ch.device           <= nxt.dev;
          in_ch.event_time       <= nxt.t;
          in_ch.cameras_required <= nxt.cams;
        end
      end
    end
  end

  // monitor: checks each result transfer and shapes ready
  always @(posedge clk) begin : observe
    hb_status_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (status_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result, vector %h", out_ch.state_vector));
        end else begin
          want = status_q.pop_front();
          if (out_ch.state_vector !== want.vec)
            report_mismatch($sformatf("state_vector %h, want %h",
                                      out_ch.state_vector, want.vec));
          if (out_ch.queried_state !== want.q)
            report_mismatch($sformatf("queried_state %0d, want %0d",
                                      out_ch.queried_state, want.q));
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (hold_seen != hold_reqs) begin
        hold_seen = hold_reqs;
        hold_left = LONG_HOLD - 1;
        out_ch.ready <= 1'b0;
      end else if (snk_gap > 0) begin
        snk_gap--;
        out_ch.ready <= 1'b0;
      end else if (snk_pct != 0 && $urandom_range(1, 100) <= snk_pct) begin
        snk_gap = $urandom_range(0, 18);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // register write, mirrored into the model while the block is idle
  task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_APPLICABLE: appl_m  = data[MASK_W-1:0];
      CFG_CONFIGURED: conf_m  = data[MASK_W-1:0];
      CFG_CAMERA:     cam_m   = data[MASK_W-1:0];
      CFG_INIT_TO:    init_to = data;
      CFG_ERROR_TO:   err_to  = data;
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [MASK_W-1:0] appl, input logic [MASK_W-1:0] conf,
                            input logic [MASK_W-1:0] cam, input logic [CFG_W-1:0] ito,
                            input logic [CFG_W-1:0] eto);
    write_reg(CFG_APPLICABLE, CFG_W'(appl));
    write_reg(CFG_CONFIGURED, CFG_W'(conf));
    write_reg(CFG_CAMERA, CFG_W'(cam));
    write_reg(CFG_INIT_TO, ito);
    write_reg(CFG_ERROR_TO, eto);
  endtask

  task automatic queue_item(input op_e op, input logic [DEVF_W-1:0] dev,
                            input logic [EVT_W-1:0] t, input logic cams);
    hb_item_t it;
    it.op   = op;
    it.dev  = dev;
    it.t    = t;
    it.cams = cams;
    item_q.push_back(it);
  endtask

  // coherent traffic around a running wall clock, with some noise
  task automatic queue_random(input int n);
    hb_item_t it;
    int       pick;
    int       lag;
    repeat (n) begin
      pick    = $urandom_range(0, 99);
      it.dev  = DEVF_W'($urandom_range(0, 7));
      it.cams = 1'($urandom_range(0, 1));
      if (pick < 2) begin
        it.op = OP_START;
        it.t  = wall;
      end else if (pick < 40) begin
        lag   = $urandom_range(0, 40);
        it.op = OP_HEARTBEAT;
        it.t  = (wall >= lag) ? wall - lag : wall;
      end else if (pick < 72) begin
        wall  = wall + $urandom_range(0, step_max);
        it.op = OP_TICK;
        it.t  = wall;
      end else if (pick < 92) begin
        it.op = OP_QUERY;
        it.t  = $urandom;
      end else begin
        // noise: any opcode, stray times; stale heartbeats only, never later than the wall clock
        it.op = op_e'($urandom_range(0, 3));
        it.t  = (it.op == OP_HEARTBEAT) ? $urandom_range(0, wall) : $urandom;
      end
      item_q.push_back(it);
    end
  endtask

  task automatic wait_idle();
    @(negedge clk);
    while (item_q.size() != 0 || in_ch.valid || status_q.size() != 0) @(negedge clk);
  endtask

  // run limit
  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("FAIL");
    $finish;
  end

  // stimulus sequence
  initial begin
    rst_n                  = 1'b0;
    cfg_we                 = 1'b0;
    cfg_idx                = CFG_APPLICABLE;
    cfg_data               = '0;
    appl_m     = APPLICABLE_RST;
    conf_m     = CONFIGURED_RST;
    cam_m      = CAMERA_RST;
    init_to    = INIT_TO_RST;
    err_to     = ERROR_TO_RST;
    src_pct    = 10;
    snk_pct    = 10;
    hold_reqs  = 0;
    step_max   = 12;
    wall       = 32'd1000;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // device 0 and 7 absent, device 6 not evaluated
    write_reg(CFG_CONFIGURED, CFG_W'(8'h7E));
    write_reg(CFG_APPLICABLE, CFG_W'(8'hBF));
    @(negedge clk);
    queue_item(OP_QUERY, 3'd7, 32'd0, 1'b0);
    queue_item(OP_TICK, 3'd0, 32'd0, 1'b0);
    queue_item(OP_QUERY, 3'd1, 32'd0, 1'b0);
    queue_item(OP_QUERY, 3'd0, 32'd0, 1'b0);
    wait_idle();

    // all devices present: settle, boundaries, cameras, start keeping state
    write_reg(CFG_CONFIGURED, CFG_W'(8'hFF));
    write_reg(CFG_APPLICABLE, CFG_W'(8'hFF));
    @(negedge clk);
    queue_item(OP_TICK, 3'd5, 32'd5, 1'b1);
    queue_item(OP_START, 3'd0, 32'd100, 1'b0);
    queue_item(OP_HEARTBEAT, 3'd0, 32'd105, 1'b0);
    queue_item(OP_HEARTBEAT, 3'd0, 32'd103, 1'b1);
    queue_item(OP_TICK, 3'd0, 32'd110, 1'b0);
    queue_item(OP_QUERY, 3'd0, 32'd0, 1'b0);
    queue_item(OP_TICK, 3'd0, 32'd111, 1'b1);
    queue_item(OP_TICK, 3'd0, 32'd125, 1'b1);
    queue_item(OP_QUERY, 3'd0, 32'd0, 1'b0);
    queue_item(OP_TICK, 3'd0, 32'd126, 1'b0);
    queue_item(OP_QUERY, 3'd6, 32'd0, 1'b0);
    queue_item(OP_QUERY, 3'd3, 32'hFFFF_FFFF, 1'b1);
    queue_item(OP_START, 3'd7, 32'd200, 1'b1);
    queue_item(OP_QUERY, 3'd7, 32'd0, 1'b0);
    queue_item(OP_HEARTBEAT, 3'd7, 32'd0, 1'b0);
    // sums near the top of the time range must not wrap
    queue_item(OP_START, 3'd0, 32'hFFFF_FFF0, 1'b0);
    queue_item(OP_TICK, 3'd0, 32'hFFFF_FFFF, 1'b1);
    queue_item(OP_START, 3'd0, 32'hFFFF_FFE0, 1'b0);
    queue_item(OP_TICK, 3'd7, 32'hFFFF_FFFF, 1'b0);
    queue_item(OP_QUERY, 3'd7, 32'd0, 1'b0);
    queue_item(OP_START, 3'd0, 32'd0, 1'b0);
    queue_item(OP_TICK, 3'd0, 32'd30, 1'b0);
    queue_item(OP_QUERY, 3'd6, 32'd0, 1'b0);
    wait_idle();

    // random phases under changing configuration
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0, 9: set_config(APPLICABLE_RST, CONFIGURED_RST, CAMERA_RST, INIT_TO_RST,
                         ERROR_TO_RST);
        1: set_config(8'hFF, 8'hFF, 8'h00, '0, '0);
        2: set_config(8'hFF, 8'hFF, 8'hFF, '1, '1);
        3: set_config(8'h00, 8'h00, 8'h00, {$urandom, $urandom}, {$urandom, $urandom});
        default: set_config(MASK_W'($urandom), MASK_W'($urandom), MASK_W'($urandom),
                            {$urandom, $urandom}, {$urandom, $urandom});
      endcase
      step_max = (ph == 2) ? 80 : ((ph % 2) ? 40 : 12);
      if (ph == 6 || ph == 9) begin
        src_pct = 0;
        snk_pct = 0;
      end else begin
        src_pct = $urandom_range(5, 30);
        snk_pct = $urandom_range(5, 30);
      end
      if (ph == 9) wall = 32'hFFFF_FE00;
      @(negedge clk);
      queue_item(OP_START, DEVF_W'($urandom_range(0, 7)), wall, 1'($urandom_range(0, 1)));
      queue_random(PHASE_ITEMS);
      if (ph == 2 || ph == 6) hold_reqs++;
      wait_idle();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (status_q.size() != 0) report_mismatch("results still outstanding");
    if (mismatches == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

### multi_device_heartbeat_monitor.f
rtl/hbm_pkg.sv
rtl/hbm_in_if.sv
rtl/hbm_out_if.sv
rtl/multi_device_heartbeat_monitor.sv
sim/testbench.sv
